FILE: src/sea_pkg.sv
// ----------------------------------------------------------------------------
// sea_pkg
// Shared types and constants for the span extent accumulator.
// ----------------------------------------------------------------------------
package sea_pkg;

  localparam int unsigned ROW_W  = 8;
  localparam int unsigned X_W    = 16;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ROW_SPAN = 2 ** ROW_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOWER = 3'd3;

  localparam logic signed [X_W-1:0] SPAN_EMPTY_LEFT  = 16'sh7fff;
  localparam logic signed [X_W-1:0] SPAN_EMPTY_RIGHT = 16'sh8000;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_RANGE,
    OP_LOWER,
    OP_QUERY
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [ROW_W-1:0]        row;
    logic signed [X_W-1:0]   x_lo;
    logic signed [X_W-1:0]   x_hi;
  } in_item_t;

  typedef struct packed {
    logic signed [X_W-1:0]   left;
    logic signed [X_W-1:0]   right;
    logic [ROW_W-1:0]        first_row;
    logic [ROW_W-1:0]        last_row;
    logic                    region_valid;
  } out_item_t;

  typedef struct packed {
    op_e                     op;
    logic                    in_range;
    logic [ROW_W-1:0]        row;
    logic signed [X_W-1:0]   x_lo;
    logic signed [X_W-1:0]   x_hi;
  } cls_t;

  typedef struct packed {
    logic empty;
    cls_t head;
  } cmdq_stat_t;

endpackage

FILE: src/sea_ram.sv
// ----------------------------------------------------------------------------
// sea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sea_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sea_front.sv
// ----------------------------------------------------------------------------
// sea_front
// Accepts input transactions, decodes the command and row range, and
// holds the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sea_front #(
  parameter int unsigned ROWS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sea_pkg::in_item_t   in_item_i,
  input  logic                pop_i,
  output sea_pkg::cmdq_stat_t stat_o
);

  localparam int unsigned QDEPTH = 2;

  sea_pkg::cls_t     entries_q [QDEPTH];
  sea_pkg::cls_t     cls;
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              do_push;
  logic              do_pop;

  // classify
  always_comb begin
    cls.row      = in_item_i.row;
    cls.x_lo     = in_item_i.x_lo;
    cls.x_hi     = in_item_i.x_hi;
    cls.in_range = (32'(in_item_i.row) < ROWS);
    case (in_item_i.cmd)
      sea_pkg::CMD_CLEAR: cls.op = sea_pkg::OP_CLEAR;
      sea_pkg::CMD_ADD:   cls.op = cls.in_range ? sea_pkg::OP_ADD   : sea_pkg::OP_QUERY;
      sea_pkg::CMD_RANGE: cls.op = cls.in_range ? sea_pkg::OP_RANGE : sea_pkg::OP_QUERY;
      sea_pkg::CMD_LOWER: cls.op = cls.in_range ? sea_pkg::OP_LOWER : sea_pkg::OP_QUERY;
      default:            cls.op = sea_pkg::OP_QUERY;
    endcase
  end

  assign full    = (count_q == 2'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

  assign stat_o.empty = (count_q == 2'd0);
  assign stat_o.head  = entries_q[rd_ptr_q];

endmodule

FILE: src/sea_back.sv
// ----------------------------------------------------------------------------
// sea_back
// Executes classified items: reads the row span, merges an add's sample and
// writes it back, tracks the row range and registers the result.
// ----------------------------------------------------------------------------
module sea_back #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sea_pkg::cmdq_stat_t stat_i,
  output logic                pop_o,
  output logic                empty,
  input  logic                pop,
  output sea_pkg::out_item_t  out_item_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned SPAN_W = 2 * sea_pkg::X_W;

  sea_pkg::state_e             state_q, state_d;
  sea_pkg::cls_t               item_q;
  logic [DEPTH-1:0]            written_q, written_d;
  logic [sea_pkg::ROW_W-1:0]   first_q, first_d;
  logic [sea_pkg::ROW_W-1:0]   last_q, last_d;
  logic                        nf_q, nf_d;
  logic                        nl_q, nl_d;
  sea_pkg::out_item_t          res_q, res_d;
  logic                        res_valid_q, res_valid_d;

  logic                        fetch;
  logic                        fire;
  logic                        out_free;
  logic [IDX_W-1:0]            idx;
  logic [SPAN_W-1:0]           rdata;
  logic [SPAN_W-1:0]           wdata;
  logic                        we;
  logic                        was_written;
  logic signed [sea_pkg::X_W-1:0] old_l, old_r, new_l, new_r;
  logic                        region_ok;

  sea_ram #(
    .WIDTH (SPAN_W),
    .DEPTH (DEPTH)
  ) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (wdata),
    .re_i    (fetch),
    .raddr_i (stat_i.head.row[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign out_free = !res_valid_q || pop;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sea_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          state_d = sea_pkg::ST_UPDATE;
        end
      end
      sea_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = sea_pkg::ST_IDLE;
        end
      end
      default: state_d = sea_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    fetch = 1'b0;
    fire  = 1'b0;
    case (state_q)
      sea_pkg::ST_IDLE:   fetch = !stat_i.empty;
      sea_pkg::ST_UPDATE: fire  = out_free;
      default: begin
        fetch = 1'b0;
        fire  = 1'b0;
      end
    endcase
  end

  assign pop_o = fetch;

  // span merge
  assign idx         = item_q.row[IDX_W-1:0];
  assign was_written = item_q.in_range && written_q[idx];
  assign old_l       = $signed(rdata[SPAN_W-1:sea_pkg::X_W]);
  assign old_r       = $signed(rdata[sea_pkg::X_W-1:0]);

  always_comb begin
    new_l = item_q.x_lo;
    new_r = item_q.x_hi;
    if (was_written) begin
      new_l = ($signed(item_q.x_lo) < old_l) ? item_q.x_lo : old_l;
      new_r = ($signed(item_q.x_hi) > old_r) ? item_q.x_hi : old_r;
    end
  end

  assign we    = fire && (item_q.op == sea_pkg::OP_ADD);
  assign wdata = {new_l, new_r};

  // range and written bits
  always_comb begin
    written_d = written_q;
    first_d   = first_q;
    last_d    = last_q;
    nf_d      = nf_q;
    nl_d      = nl_q;
    if (fire) begin
      case (item_q.op)
        sea_pkg::OP_CLEAR: begin
          written_d = '0;
          first_d   = '0;
          last_d    = '0;
          nf_d      = 1'b0;
          nl_d      = 1'b0;
        end
        sea_pkg::OP_ADD, sea_pkg::OP_RANGE: begin
          if (item_q.op == sea_pkg::OP_ADD) begin
            written_d[idx] = 1'b1;
          end
          if (!nf_q || item_q.row < first_q) begin
            first_d = item_q.row;
          end
          if (!nl_q || item_q.row > last_q) begin
            last_d = item_q.row;
          end
          nf_d = 1'b1;
          nl_d = 1'b1;
        end
        sea_pkg::OP_LOWER: begin
          if (!nf_q || item_q.row < first_q) begin
            first_d = item_q.row;
          end
          nf_d = 1'b1;
        end
        default: begin
          nf_d = nf_q;
        end
      endcase
    end
  end

  assign region_ok = nf_d && nl_d && (first_d <= last_d);

  // result
  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop;
    if (fire) begin
      res_valid_d = 1'b1;
      if (item_q.op == sea_pkg::OP_ADD) begin
        res_d.left  = new_l;
        res_d.right = new_r;
      end else if (was_written && item_q.op != sea_pkg::OP_CLEAR) begin
        res_d.left  = old_l;
        res_d.right = old_r;
      end else begin
        res_d.left  = sea_pkg::SPAN_EMPTY_LEFT;
        res_d.right = sea_pkg::SPAN_EMPTY_RIGHT;
      end
      res_d.first_row    = region_ok ? first_d : '0;
      res_d.last_row     = region_ok ? last_d  : '0;
      res_d.region_valid = region_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sea_pkg::ST_IDLE;
      written_q   <= '0;
      first_q     <= '0;
      last_q      <= '0;
      nf_q        <= 1'b0;
      nl_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      written_q   <= written_d;
      first_q     <= first_d;
      last_q      <= last_d;
      nf_q        <= nf_d;
      nl_q        <= nl_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (fetch) begin
      item_q <= stat_i.head;
    end
  end

  assign empty      = !res_valid_q;
  assign out_item_o = res_q;

endmodule

FILE: src/span_extent_accumulator_unit.sv
// ----------------------------------------------------------------------------
// span_extent_accumulator_unit
// Scanline span table of a convex region, built from edge samples.
//
//   port        dir  handshake          payload
//   in_item_i   in   push / full        cmd, row, x_lo, x_hi
//   out_item_o  out  empty / pop        left, right, first_row, last_row,
//                                       region_valid
//
// Per transaction: span RAM read in ST_IDLE, then merge, write back and result
// update in ST_UPDATE (held while the result is unpopped); one at a time.
// A two-entry command queue lets the front keep accepting while the back
// end works; the result register frees the back end once a result is popped.
// Reset clears the row range and all per-row written bits at once.
// ----------------------------------------------------------------------------
module span_extent_accumulator_unit #(
  parameter int unsigned ROWS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sea_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output sea_pkg::out_item_t out_item_o
);

  localparam int unsigned DEPTH = (ROWS < sea_pkg::ROW_SPAN) ? ROWS : sea_pkg::ROW_SPAN;

  sea_pkg::cmdq_stat_t cmdq_stat;
  logic                cmdq_pop;

  sea_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .pop_i     (cmdq_pop),
    .stat_o    (cmdq_stat)
  );

  sea_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (cmdq_stat),
    .pop_o      (cmdq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmdq_pop |-> !cmdq_stat.empty)
    else $error("command queue popped while empty");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.region_valid) |-> (out_item_o.first_row <= out_item_o.last_row))
    else $error("valid region with first row above last row");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.region_valid) |->
      (out_item_o.first_row == '0 && out_item_o.last_row == '0))
    else $error("invalid region reports nonzero rows");

  a_fetch_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmdq_pop |=> !cmdq_pop)
    else $error("back end fetched two transactions in a row");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for span_extent_accumulator_unit. Directed transactions
// cover clear, sample add, range only, lower first row, query and the unused
// commands, span and range extremes and reversed samples. Random polygon
// outlines on small row windows with random x content, mixed with noise
// transactions, follow. A built-in span table model predicts every result
// and the monitor checks each popped result field by field, under three
// phases of sender and receiver idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_ROWS          = 256;
  localparam int ITEMS_PER_PHASE = 360;
  localparam int RX_HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_PRINTS      = 50;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               pop       = 1'b0;
  sea_pkg::in_item_t  in_item_i = '0;
  logic               full;
  logic               empty;
  sea_pkg::out_item_t out_item_o;

  sea_pkg::in_item_t  sample_queue[$];
  sea_pkg::out_item_t expected_spans[$];
  sea_pkg::out_item_t span_want;
  int                 mismatch_count = 0;
  int                 tx_idle_pct    = 0;
  int                 rx_idle_pct    = 0;
  int                 rx_hold_seq    = 0;
  int                 rx_hold_seen   = 0;
  int                 rx_hold_left   = 0;

  // span table model state
  logic signed [sea_pkg::X_W-1:0] tbl_left [N_ROWS];
  logic signed [sea_pkg::X_W-1:0] tbl_right[N_ROWS];
  logic [N_ROWS-1:0]              tbl_written = '0;
  logic [sea_pkg::ROW_W-1:0]      rng_first   = '0;
  logic [sea_pkg::ROW_W-1:0]      rng_last    = '0;
  logic                           has_first   = 1'b0;
  logic                           has_last    = 1'b0;

  span_extent_accumulator_unit #(
    .ROWS(N_ROWS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void widen_row_range(logic [sea_pkg::ROW_W-1:0] r);
    if (!has_first || r < rng_first) begin
      rng_first = r;
    end
    if (!has_last || r > rng_last) begin
      rng_last = r;
    end
    has_first = 1'b1;
    has_last  = 1'b1;
  endfunction

  function automatic sea_pkg::out_item_t span_table_update(sea_pkg::in_item_t it);
    sea_pkg::out_item_t res;
    logic               row_ok;
    logic               valid;
    row_ok = int'(it.row) < N_ROWS;
    case (it.cmd)
      sea_pkg::OP_CLEAR: begin
        tbl_written = '0;
        rng_first   = '0;
        rng_last    = '0;
        has_first   = 1'b0;
        has_last    = 1'b0;
      end
      sea_pkg::OP_ADD: if (row_ok) begin
        if (!tbl_written[it.row]) begin
          tbl_left[it.row]    = it.x_lo;
          tbl_right[it.row]   = it.x_hi;
          tbl_written[it.row] = 1'b1;
        end else begin
          if (it.x_lo < tbl_left[it.row]) begin
            tbl_left[it.row] = it.x_lo;
          end
          if (it.x_hi > tbl_right[it.row]) begin
            tbl_right[it.row] = it.x_hi;
          end
        end
        widen_row_range(it.row);
      end
      sea_pkg::OP_RANGE: if (row_ok) begin
        widen_row_range(it.row);
      end
      sea_pkg::OP_LOWER: if (row_ok) begin
        if (!has_first || it.row < rng_first) begin
          rng_first = it.row;
        end
        has_first = 1'b1;
      end
      default: ;
    endcase
    res.left  = sea_pkg::SPAN_EMPTY_LEFT;
    res.right = sea_pkg::SPAN_EMPTY_RIGHT;
    if (row_ok && tbl_written[it.row]) begin
      res.left  = tbl_left[it.row];
      res.right = tbl_right[it.row];
    end
    valid            = has_first && has_last && rng_first <= rng_last;
    res.first_row    = valid ? rng_first : '0;
    res.last_row     = valid ? rng_last : '0;
    res.region_valid = valid;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic logic [sea_pkg::CMD_W-1:0] cmd_bits(int c);
    return c[sea_pkg::CMD_W-1:0];
  endfunction

  function automatic sea_pkg::in_item_t mk(logic [sea_pkg::CMD_W-1:0] c, int r, int lo,
                                           int hi);
    sea_pkg::in_item_t it;
    it.cmd  = c;
    it.row  = r[sea_pkg::ROW_W-1:0];
    it.x_lo = lo[sea_pkg::X_W-1:0];
    it.x_hi = hi[sea_pkg::X_W-1:0];
    return it;
  endfunction

  function automatic int rand_x();
    case ($urandom_range(7))
      0:       return int'(sea_pkg::SPAN_EMPTY_RIGHT);
      1:       return int'(sea_pkg::SPAN_EMPTY_LEFT);
      default: return int'($signed(16'($urandom_range(65535))));
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_item_i <= '0;
    end else begin
      if (push && !full) begin
        expected_spans.push_back(span_table_update(in_item_i));
      end
      if (push && full) begin
        // hold the offered transaction
      end else if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_item_i <= sample_queue.pop_front();
        push      <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_spans.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          span_want = expected_spans.pop_front();
          check_field("left", int'(out_item_o.left), int'(span_want.left));
          check_field("right", int'(out_item_o.right), int'(span_want.right));
          check_field("first_row", int'(out_item_o.first_row), int'(span_want.first_row));
          check_field("last_row", int'(out_item_o.last_row), int'(span_want.last_row));
          check_field("region_valid", int'(out_item_o.region_valid),
                      int'(span_want.region_valid));
        end
      end
      if (rx_hold_seq != rx_hold_seen) begin
        rx_hold_seen <= rx_hold_seq;
        rx_hold_left <= RX_HOLD_CYCLES;
        pop          <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        pop          <= 1'b0;
      end else begin
        pop <= $urandom_range(99) >= rx_idle_pct;
      end
    end
  end

  // one convex outline: optional clear, left edge down, right edge up, then queries
  task automatic queue_polygon();
    int top, bot, r, xl, xr, n;
    top = $urandom_range(N_ROWS - 1);
    bot = top + $urandom_range(20);
    if (bot > N_ROWS - 1) begin
      bot = N_ROWS - 1;
    end
    if ($urandom_range(9) != 0) begin
      sample_queue.push_back(mk(sea_pkg::OP_CLEAR, $urandom_range(255), rand_x(), rand_x()));
    end
    xl = $urandom_range(4000) - 2000;
    xr = xl + $urandom_range(3000);
    if ($urandom_range(3) == 0) begin
      sample_queue.push_back(mk(sea_pkg::OP_ADD, top, xl, xr));
    end
    for (r = top; r <= bot; r++) begin
      xl = xl + $urandom_range(16) - 8;
      case ($urandom_range(9))
        0:       sample_queue.push_back(mk(sea_pkg::OP_RANGE, r, rand_x(), rand_x()));
        1: begin
          n = r - $urandom_range(3);
          sample_queue.push_back(mk(sea_pkg::OP_LOWER, n < 0 ? 0 : n, rand_x(), rand_x()));
        end
        default: sample_queue.push_back(mk(sea_pkg::OP_ADD, r, xl, xl));
      endcase
    end
    for (r = bot; r >= top; r--) begin
      xr = xr + $urandom_range(16) - 8;
      sample_queue.push_back(mk(sea_pkg::OP_ADD, r, xr, xr));
    end
    n = $urandom_range(6, 1);
    repeat (n) begin
      r = top - 2 + $urandom_range(bot - top + 4);
      r = r < 0 ? 0 : (r > N_ROWS - 1 ? N_ROWS - 1 : r);
      sample_queue.push_back(
        mk(cmd_bits($urandom_range(2 ** sea_pkg::CMD_W - 1, int'(sea_pkg::OP_QUERY))), r,
           rand_x(), rand_x()));
    end
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || push) @(negedge clk_i);
    while (expected_spans.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int phase, c;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni      = 1'b1;
    tx_idle_pct = 15;
    rx_idle_pct = 45;

    sample_queue.push_back(mk(sea_pkg::OP_QUERY, 0, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_LOWER, 10, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 20, int'(sea_pkg::SPAN_EMPTY_RIGHT),
                              int'(sea_pkg::SPAN_EMPTY_LEFT)));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 20, 5, -5));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 255, int'(sea_pkg::SPAN_EMPTY_LEFT),
                              int'(sea_pkg::SPAN_EMPTY_RIGHT)));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 255, 100, 200));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 255, 300, 50));
    sample_queue.push_back(mk(sea_pkg::OP_RANGE, 0, -1, -1));
    sample_queue.push_back(mk(sea_pkg::OP_LOWER, 0, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_QUERY, 20, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_QUERY, 7, 0, 0));
    for (c = int'(sea_pkg::OP_QUERY) + 1; c < 2 ** sea_pkg::CMD_W; c++) begin
      sample_queue.push_back(mk(cmd_bits(c), 255, -1, 0));
    end
    sample_queue.push_back(mk(sea_pkg::OP_CLEAR, 20, 1, 1));
    sample_queue.push_back(mk(sea_pkg::OP_QUERY, 20, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_LOWER, 200, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_RANGE, 100, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_RANGE, 128, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_LOWER, 150, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 0, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_ADD, 0, -1, 1));
    sample_queue.push_back(mk(sea_pkg::OP_CLEAR, 255, -1, -1));
    sample_queue.push_back(mk(sea_pkg::OP_RANGE, 255, 0, 0));
    sample_queue.push_back(mk(sea_pkg::OP_QUERY, 0, 0, 0));
    drain();

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = phase == 0 ? 15 : (phase == 1 ? 45 : 0);
      rx_idle_pct = phase == 0 ? 45 : (phase == 1 ? 15 : 0);
      if (phase != 1) begin
        rx_hold_seq++;
      end
      while (sample_queue.size() < ITEMS_PER_PHASE) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(8, 1)) begin
            sample_queue.push_back(mk(cmd_bits($urandom_range(2 ** sea_pkg::CMD_W - 1)),
                                      $urandom_range(255), rand_x(), rand_x()));
          end
        end else begin
          queue_polygon();
        end
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
src/sea_pkg.sv
src/sea_ram.sv
src/sea_front.sv
src/sea_back.sv
src/span_extent_accumulator_unit.sv
dv/testbench.sv
